FILE: rtl/core/wtf8sd_pkg.sv
`default_nettype none
package wtf8sd_pkg;

   localparam int LENGTH_BITS = 32;
   localparam int COUNT_W     = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;
   localparam int MAX_RESULTS = 3;
   localparam int SLOT_W      = $clog2(MAX_RESULTS);
   localparam int NUM_W       = $clog2(MAX_RESULTS + 1);

   typedef enum logic [1:0] {
      CLS_ASCII   = 2'd0,
      CLS_LATIN1  = 2'd1,
      CLS_UTF16   = 2'd2,
      CLS_INVALID = 2'd3
   } enc_class_type;

   typedef enum logic {
      KIND_UNIT   = 1'b0,
      KIND_STATUS = 1'b1
   } result_kind_type;

   typedef struct packed {
      logic        result_kind;
      logic [15:0] code_unit;
      logic [1:0]  encoding_class;
      logic [31:0] utf16_units;
      logic        run_last;
   } result_type;

   typedef struct packed {
      logic [NUM_W-1:0]                   count;
      result_type [MAX_RESULTS-1:0]       slot;
   } bundle_type;

endpackage
`default_nettype wire

FILE: rtl/core/wtf8sd_req_if.sv
`default_nettype none
interface wtf8sd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_string;

   modport source (output valid, output in_byte, output end_of_string, input ready);
   modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/wtf8sd_rsp_if.sv
`default_nettype none
interface wtf8sd_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [15:0] code_unit;
   logic [1:0]  encoding_class;
   logic [31:0] utf16_units;
   logic        run_last;

   modport source (output valid, output result_kind, output code_unit,
                   output encoding_class, output utf16_units, output run_last,
                   input ready);
   modport sink   (input valid, input result_kind, input code_unit,
                   input encoding_class, input utf16_units, input run_last,
                   output ready);
endinterface
`default_nettype wire

FILE: rtl/core/wtf8_stream_decoder_core.sv
// A byte's first result is presented in the cycle after the byte is accepted.
// Throughput: one input byte per cycle while each byte yields at most one result and
//   rsp_chan is ready; a byte with n results (up to 3) stalls input until the last
//   is taken. The result queue holding one byte's results sets that rate.
// Reset (synchronous, active high) clears the decoder state, the result queue and
//   one_byte_output; string state also clears after each end-of-string byte.
`default_nettype none
module wtf8_stream_decoder_core (
   input  wire logic      clock,
   input  wire logic      reset,
   wtf8sd_req_if.sink     req_chan,
   wtf8sd_rsp_if.source   rsp_chan,
   input  wire logic      csr_write_enable,
   input  wire logic      csr_write_data
);

   logic                    one_byte_output_ff;
   logic                    advance;
   logic                    load_ready;
   wtf8sd_pkg::bundle_type  bundle;
   wtf8sd_pkg::result_type  head;

   always_ff @(posedge clock) begin
      if (reset) begin
         one_byte_output_ff <= 1'b0;
      end else if (csr_write_enable) begin
         one_byte_output_ff <= csr_write_data;
      end
   end

   assign req_chan.ready = load_ready;
   assign advance        = req_chan.valid && load_ready;

   wtf8sd_decode u_decode (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .in_byte         (req_chan.in_byte),
      .end_of_string   (req_chan.end_of_string),
      .one_byte_output (one_byte_output_ff),
      .bundle          (bundle)
   );

   wtf8sd_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .load_valid (req_chan.valid),
      .load_ready (load_ready),
      .bundle     (bundle),
      .head_valid (rsp_chan.valid),
      .head_ready (rsp_chan.ready),
      .head       (head)
   );

   assign rsp_chan.result_kind    = head.result_kind;
   assign rsp_chan.code_unit      = head.code_unit;
   assign rsp_chan.encoding_class = head.encoding_class;
   assign rsp_chan.utf16_units    = head.utf16_units;
   assign rsp_chan.run_last       = head.run_last;

endmodule
`default_nettype wire

FILE: rtl/core/wtf8sd_decode.sv
`default_nettype none
module wtf8sd_decode (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire logic [7:0]              in_byte,
   input  wire logic                    end_of_string,
   input  wire logic                    one_byte_output,
   output wtf8sd_pkg::bundle_type       bundle
);

   typedef enum logic [2:0] {
      ST_ACCEPT   = 3'd0,
      ST_REJECT   = 3'd1,
      ST_NEED1    = 3'd2,
      ST_NEED2    = 3'd3,
      ST_NEED2_E0 = 3'd4,
      ST_NEED3    = 3'd5,
      ST_NEED3_F0 = 3'd6,
      ST_NEED3_F4 = 3'd7
   } dfa_state_type;

   dfa_state_type                  dfa_ff, dfa_in, step_dfa, nxt;
   logic [20:0]                    part_ff, part_in, step_part, cp, v;
   logic                           prior_ff, prior_in;
   logic                           ascii_ff, ascii_in;
   logic                           fits_ff, fits_in;
   logic                           err_ff, err_in;
   logic [wtf8sd_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [wtf8sd_pkg::COUNT_W:0]   sum;
   logic [7:0]                     lo, hi;
   logic                           is_trail, is_lead;
   logic [1:0]                     n_units;
   logic [15:0]                    unit0, unit1;
   logic [1:0]                     cls;

   // one step of the generalized UTF-8 automaton
   always_comb begin
      lo        = 8'h80;
      hi        = 8'hBF;
      nxt       = ST_REJECT;
      step_part = part_ff;
      step_dfa  = ST_REJECT;
      if (dfa_ff == ST_ACCEPT) begin
         if (!in_byte[7]) begin
            step_part = 21'(in_byte);
            step_dfa  = ST_ACCEPT;
         end else if (in_byte >= 8'hC2 && in_byte <= 8'hDF) begin
            step_part = 21'(in_byte[4:0]);
            step_dfa  = ST_NEED1;
         end else if (in_byte == 8'hE0) begin
            step_part = 21'(in_byte[3:0]);
            step_dfa  = ST_NEED2_E0;
         end else if (in_byte >= 8'hE1 && in_byte <= 8'hEF) begin
            step_part = 21'(in_byte[3:0]);
            step_dfa  = ST_NEED2;
         end else if (in_byte == 8'hF0) begin
            step_part = 21'(in_byte[2:0]);
            step_dfa  = ST_NEED3_F0;
         end else if (in_byte >= 8'hF1 && in_byte <= 8'hF3) begin
            step_part = 21'(in_byte[2:0]);
            step_dfa  = ST_NEED3;
         end else if (in_byte == 8'hF4) begin
            step_part = 21'(in_byte[2:0]);
            step_dfa  = ST_NEED3_F4;
         end
      end else begin
         unique case (dfa_ff)
            ST_NEED1:    nxt = ST_ACCEPT;
            ST_NEED2:    nxt = ST_NEED1;
            ST_NEED2_E0: begin
               lo  = 8'hA0;
               nxt = ST_NEED1;
            end
            ST_NEED3:    nxt = ST_NEED2;
            ST_NEED3_F0: begin
               lo  = 8'h90;
               nxt = ST_NEED2;
            end
            ST_NEED3_F4: begin
               hi  = 8'h8F;
               nxt = ST_NEED2;
            end
            default: begin
               lo  = 8'h01;
               hi  = 8'h00;
               nxt = ST_REJECT;
            end
         endcase
         if (in_byte >= lo && in_byte <= hi) begin
            step_part = {part_ff[14:0], in_byte[5:0]};
            step_dfa  = nxt;
         end
      end
   end

   assign cp       = step_part;
   assign v        = cp - 21'h010000;
   assign is_trail = (cp >= 21'h00DC00) && (cp <= 21'h00DFFF);
   assign is_lead  = (cp >= 21'h00D800) && (cp <= 21'h00DBFF);
   assign sum      = {1'b0, count_ff}
                   + ((cp > 21'h00FFFF) ? (wtf8sd_pkg::COUNT_W+1)'(2)
                                        : (wtf8sd_pkg::COUNT_W+1)'(1));

   always_comb begin
      dfa_in   = dfa_ff;
      part_in  = part_ff;
      prior_in = prior_ff;
      ascii_in = ascii_ff;
      fits_in  = fits_ff;
      err_in   = err_ff;
      count_in = count_ff;
      n_units  = 2'd0;
      unit0    = 16'h0000;
      unit1    = 16'h0000;
      if (!err_ff) begin
         ascii_in = ascii_ff & ~in_byte[7];
         dfa_in   = step_dfa;
         part_in  = step_part;
         if (step_dfa == ST_REJECT) begin
            err_in = 1'b1;
         end else if (step_dfa == ST_ACCEPT) begin
            part_in = '0;
            if (is_trail && prior_ff) begin
               err_in = 1'b1;
            end else begin
               if (cp > 21'h0000FF) begin
                  fits_in = 1'b0;
               end
               count_in = sum[wtf8sd_pkg::COUNT_W] ? '1 : sum[wtf8sd_pkg::COUNT_W-1:0];
               prior_in = is_lead;
               if (one_byte_output) begin
                  n_units = 2'd1;
                  unit0   = {8'h00, cp[7:0]};
               end else if (cp <= 21'h00FFFF) begin
                  n_units = 2'd1;
                  unit0   = cp[15:0];
               end else begin
                  n_units = 2'd2;
                  unit0   = 16'hD800 | {6'b000000, v[19:10]};
                  unit1   = 16'hDC00 | {6'b000000, v[9:0]};
               end
            end
         end
      end
   end

   always_comb begin
      if (err_in || dfa_in != ST_ACCEPT) begin
         cls = wtf8sd_pkg::CLS_INVALID;
      end else if (ascii_in) begin
         cls = wtf8sd_pkg::CLS_ASCII;
      end else if (fits_in) begin
         cls = wtf8sd_pkg::CLS_LATIN1;
      end else begin
         cls = wtf8sd_pkg::CLS_UTF16;
      end
   end

   always_comb begin
      bundle      = '0;
      if (n_units != 2'd0) begin
         bundle.slot[0].result_kind = wtf8sd_pkg::KIND_UNIT;
         bundle.slot[0].code_unit   = unit0;
      end
      if (n_units == 2'd2) begin
         bundle.slot[1].result_kind = wtf8sd_pkg::KIND_UNIT;
         bundle.slot[1].code_unit   = unit1;
      end
      bundle.count = wtf8sd_pkg::NUM_W'(n_units);
      if (end_of_string) begin
         bundle.slot[n_units].result_kind    = wtf8sd_pkg::KIND_STATUS;
         bundle.slot[n_units].encoding_class = cls;
         bundle.slot[n_units].utf16_units    = 32'(count_in);
         bundle.count                        = wtf8sd_pkg::NUM_W'(n_units) + 2'd1;
      end
      if (bundle.count != '0) begin
         bundle.slot[wtf8sd_pkg::SLOT_W'(bundle.count - 2'd1)].run_last = 1'b1;
      end
   end

   // string state clears on the end-of-string transaction
   always_ff @(posedge clock) begin
      if (reset || (advance && end_of_string)) begin
         dfa_ff   <= ST_ACCEPT;
         part_ff  <= '0;
         prior_ff <= 1'b0;
         ascii_ff <= 1'b1;
         fits_ff  <= 1'b1;
         err_ff   <= 1'b0;
         count_ff <= '0;
      end else if (advance) begin
         dfa_ff   <= dfa_in;
         part_ff  <= part_in;
         prior_ff <= prior_in;
         ascii_ff <= ascii_in;
         fits_ff  <= fits_in;
         err_ff   <= err_in;
         count_ff <= count_in;
      end
   end

   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      advance && end_of_string |=> dfa_ff == ST_ACCEPT && !err_ff && count_ff == '0)
      else $error("string state not cleared after end of string");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      err_ff && !(advance && end_of_string) |=> err_ff)
      else $error("error flag dropped inside a string");

   a_no_units_after_error: assert property (@(posedge clock) disable iff (reset)
      err_ff |-> n_units == 2'd0)
      else $error("code unit produced after an error");

   a_status_present: assert property (@(posedge clock) disable iff (reset)
      end_of_string |-> bundle.count != '0)
      else $error("end of string without a status result");

endmodule
`default_nettype wire

FILE: rtl/core/wtf8sd_serializer.sv
`default_nettype none
module wtf8sd_serializer (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load_valid,
   output logic                         load_ready,
   input  wire wtf8sd_pkg::bundle_type  bundle,
   output logic                         head_valid,
   input  wire logic                    head_ready,
   output wtf8sd_pkg::result_type       head
);

   logic [wtf8sd_pkg::NUM_W-1:0]                   cnt_ff;
   wtf8sd_pkg::result_type [wtf8sd_pkg::MAX_RESULTS-1:0] slot_ff;
   logic                                           pop, load;

   assign head_valid = cnt_ff != '0;
   assign head       = slot_ff[0];
   assign pop        = head_valid && head_ready;
   assign load_ready = (cnt_ff == '0) || (cnt_ff == wtf8sd_pkg::NUM_W'(1) && head_ready);
   assign load       = load_valid && load_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (load) begin
         cnt_ff <= bundle.count;
      end else if (pop) begin
         cnt_ff <= cnt_ff - wtf8sd_pkg::NUM_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= bundle.slot;
      end else if (pop) begin
         for (int i = 0; i < wtf8sd_pkg::MAX_RESULTS - 1; i++) begin
            slot_ff[i] <= slot_ff[i+1];
         end
      end
   end

   a_last_flag_matches: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> head.run_last == (cnt_ff == wtf8sd_pkg::NUM_W'(1)))
      else $error("run_last does not mark the final queued result");

   a_drain_to_empty: assert property (@(posedge clock) disable iff (reset)
      pop && cnt_ff == wtf8sd_pkg::NUM_W'(1) && !load |=> cnt_ff == '0)
      else $error("queue not empty after final result taken");

   a_load_count: assert property (@(posedge clock) disable iff (reset)
      load |=> cnt_ff == $past(bundle.count))
      else $error("queue count differs from loaded bundle");

endmodule
`default_nettype wire
